// ===== sv/wsd_pkg.sv =====
package wsd_pkg;

  // Result item limits
  localparam int MAX_RESULTS   = 5;
  localparam int RCOUNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH    = 8;

  // Header field masks and codes
  localparam logic [7:0] OPCODE_MASK = 8'b0000_1111;
  localparam logic [7:0] FLAGS_MASK  = 8'b1111_0000;
  localparam logic [7:0] LEN7_MASK   = 8'b0111_1111;
  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;
  localparam logic [7:0] OP_PONG     = 8'h0a;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;

  // Extended length byte counts, modulo eight
  localparam logic [2:0] NEED_EXT16  = 3'd2;
  localparam logic [2:0] NEED_EXT64  = 3'd0;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CL_TEXT = 2'd0,
    CL_PING = 2'd1,
    CL_SKIP = 2'd2
  } frame_class_t;

  typedef enum logic [2:0] {
    EV_TEXT   = 3'd0,
    EV_EMPTY  = 3'd1,
    EV_PONG   = 3'd2,
    EV_CLOSED = 3'd3,
    EV_UNSUPP = 3'd4,
    EV_LENERR = 3'd5
  } event_kind_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  // All results caused by one received byte
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] item;
    logic [RCOUNT_W-1:0]       count;
  } burst_t;

endpackage

// ===== sv/websocket_frame_deframer.sv =====
// Path: input register, then decoder, then the registered result queue.
// Throughput: one byte per cycle; a byte may cause up to five results, which
//   leave one per cycle from the result queue while m_tready is high, so the
//   input stalls while the queue has fewer than five free slots.
// Reset: synchronous, active high; returns to the first header byte, not closed,
//   with the input stage and result queue empty.
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic [2:0] m_tuser,   // [2:0] event_kind
  output logic       m_tlast
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       take;
  logic       room;
  burst_t     burst;
  result_t    out_item;

  assign take     = in_valid && room;
  assign s_tready = !in_valid || take;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  wsd_decoder u_decoder (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (in_byte),
    .burst   (burst)
  );

  wsd_result_fifo #(
    .DEPTH (DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .burst     (burst),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = out_item.data_byte;
  assign m_tuser = out_item.event_kind;
  assign m_tlast = out_item.last;

endmodule

// ===== sv/wsd_decoder.sv =====
module wsd_decoder
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output burst_t     burst
);

  // Frame state
  phase_t       phase, phase_next;
  frame_class_t frame_class, frame_class_next;
  logic [31:0]  remaining, remaining_next;
  logic [2:0]   length_byte_index, length_byte_index_next;
  logic         closed, closed_next;

  result_t [MAX_RESULTS-1:0] res;
  logic [RCOUNT_W-1:0]       n;
  logic [3:0]                opcode;
  logic [6:0]                len7;
  logic [31:0]               rem_shift;
  logic [31:0]               rem_dec;
  logic [2:0]                idx_inc;
  logic [2:0]                need;
  logic                      hdr_done;
  logic [31:0]               hdr_rem;
  frame_class_t              hdr_class;

  assign opcode    = rx_byte[3:0] & OPCODE_MASK[3:0];
  assign len7      = rx_byte[6:0] & LEN7_MASK[6:0];
  assign rem_shift = (|remaining[31:24]) ? 32'hFFFF_FFFF : {remaining[23:0], rx_byte};
  assign rem_dec   = (remaining != 32'd0) ? remaining - 32'd1 : 32'd0;
  assign idx_inc   = length_byte_index + 3'd1;
  assign need      = (phase == PH_EXT16) ? NEED_EXT16 : NEED_EXT64;

  // Decode one byte: results and next state
  always_comb begin
    res                    = '0;
    n                      = '0;
    phase_next             = phase;
    frame_class_next       = frame_class;
    remaining_next         = remaining;
    length_byte_index_next = length_byte_index;
    closed_next            = closed;
    hdr_done               = 1'b0;
    hdr_rem                = 32'd0;
    hdr_class              = frame_class;

    if (!closed) begin
      case (phase)
        PH_HDR0: begin
          remaining_next         = 32'd0;
          length_byte_index_next = 3'd0;
          if (opcode == OP_CLOSE) begin
            closed_next = 1'b1;
            res[0]      = '{event_kind: EV_CLOSED, data_byte: 8'h00, last: 1'b0};
            n           = RCOUNT_W'(1);
          end else begin
            phase_next = PH_HDR1;
            if (opcode == OP_TEXT) begin
              frame_class_next = CL_TEXT;
            end else if (opcode == OP_PING) begin
              frame_class_next = CL_PING;
              res[0] = '{event_kind: EV_PONG,
                         data_byte: (rx_byte & FLAGS_MASK) | OP_PONG, last: 1'b0};
              n      = RCOUNT_W'(1);
            end else begin
              frame_class_next = CL_SKIP;
              res[0] = '{event_kind: EV_UNSUPP, data_byte: 8'h00, last: 1'b0};
              n      = RCOUNT_W'(1);
            end
          end
        end
        PH_HDR1: begin
          length_byte_index_next = 3'd0;
          remaining_next         = 32'd0;
          if (len7 == LEN_EXT64) begin
            if (frame_class != CL_SKIP) begin
              res[0] = '{event_kind: EV_LENERR, data_byte: 8'h00, last: 1'b0};
              n      = RCOUNT_W'(1);
            end
            frame_class_next = CL_SKIP;
            phase_next       = PH_EXT64;
          end else begin
            if (frame_class == CL_PING) begin
              res[0] = '{event_kind: EV_PONG, data_byte: rx_byte | MASK_BIT, last: 1'b0};
              n      = RCOUNT_W'(1);
            end
            if (len7 == LEN_EXT16) begin
              phase_next = PH_EXT16;
            end else begin
              remaining_next = {25'd0, len7};
              hdr_done       = 1'b1;
              hdr_rem        = {25'd0, len7};
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          if (frame_class == CL_PING) begin
            res[0] = '{event_kind: EV_PONG, data_byte: rx_byte, last: 1'b0};
            n      = RCOUNT_W'(1);
          end
          remaining_next         = rem_shift;
          length_byte_index_next = idx_inc;
          if (idx_inc == need) begin
            length_byte_index_next = 3'd0;
            hdr_done               = 1'b1;
            hdr_rem                = rem_shift;
          end
        end
        PH_PAYLOAD: begin
          remaining_next = rem_dec;
          if (frame_class == CL_TEXT) begin
            res[0] = '{event_kind: EV_TEXT, data_byte: rx_byte, last: rem_dec == 32'd0};
            n      = RCOUNT_W'(1);
          end else if (frame_class == CL_PING) begin
            res[0] = '{event_kind: EV_PONG, data_byte: rx_byte, last: rem_dec == 32'd0};
            n      = RCOUNT_W'(1);
          end
          if (rem_dec == 32'd0) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      // Header complete: mask key bytes of the pong, or the empty text event
      if (hdr_done) begin
        phase_next = (hdr_rem == 32'd0) ? PH_HDR0 : PH_PAYLOAD;
        if (hdr_class == CL_PING) begin
          for (int k = 0; k < 4; k++) begin
            res[n + RCOUNT_W'(k)] = '{event_kind: EV_PONG, data_byte: 8'h00,
                                      last: (k == 3) && (hdr_rem == 32'd0)};
          end
          n = n + RCOUNT_W'(4);
        end else if (hdr_class == CL_TEXT && hdr_rem == 32'd0) begin
          res[n] = '{event_kind: EV_EMPTY, data_byte: 8'h00, last: 1'b0};
          n      = n + RCOUNT_W'(1);
        end
      end
    end
  end

  assign burst.item  = res;
  assign burst.count = n;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      frame_class       <= CL_TEXT;
      remaining         <= 32'd0;
      length_byte_index <= 3'd0;
      closed            <= 1'b0;
    end else if (take) begin
      phase             <= phase_next;
      frame_class       <= frame_class_next;
      remaining         <= remaining_next;
      length_byte_index <= length_byte_index_next;
      closed            <= closed_next;
    end
  end

endmodule

// ===== sv/wsd_result_fifo.sv =====
module wsd_result_fifo
  import wsd_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  burst_t  burst,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = PW + 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t        entries [DEPTH];
  logic [PW-1:0]  wr_ptr, wr_ptr_next;
  logic [PW-1:0]  rd_ptr, rd_ptr_next;
  logic [CW-1:0]  count, count_next;
  logic [PW-1:0]  wr_idx [MAX_RESULTS];
  logic [SW-1:0]  idx_sum [MAX_RESULTS];
  logic [SW-1:0]  wr_sum;
  logic [SW-1:0]  rd_sum;
  logic [RCOUNT_W-1:0] push_n;
  logic           pop;

  assign push_n    = push ? burst.count : '0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign room      = (count <= CW'(DEPTH - MAX_RESULTS));

  // Write slots for each result of the burst, wrapped at the depth
  always_comb begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      idx_sum[i] = SW'(wr_ptr) + SW'(i % DEPTH);
      if (idx_sum[i] >= SW'(DEPTH)) begin
        idx_sum[i] = idx_sum[i] - SW'(DEPTH);
      end
      wr_idx[i] = idx_sum[i][PW-1:0];
    end
  end

  // Pointer and fill count updates
  always_comb begin
    wr_sum = SW'(wr_ptr) + SW'(push_n);
    if (wr_sum >= SW'(DEPTH)) begin
      wr_sum = wr_sum - SW'(DEPTH);
    end
    wr_ptr_next = wr_sum[PW-1:0];
    rd_sum = SW'(rd_ptr) + SW'(pop);
    if (rd_sum >= SW'(DEPTH)) begin
      rd_sum = rd_sum - SW'(DEPTH);
    end
    rd_ptr_next = rd_sum[PW-1:0];
    count_next  = count + CW'(push_n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Result storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (push && (RCOUNT_W'(i) < burst.count)) begin
        entries[wr_idx[i]] <= burst.item[i];
      end
    end
  end

endmodule

// ===== test/deframer_checker.sv =====
module deframer_checker
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] data_byte
  input  logic [2:0] m_tuser,   // [2:0] event_kind
  input  logic       m_tlast,
  output int         error_count,
  output int         pending_count
);

  // Deframer state as seen by the predictor
  phase_t       rx_phase;
  frame_class_t rx_class;
  logic [31:0]  rx_remaining;
  logic [2:0]   len_index;
  logic         rx_closed;

  result_t      expected_q[$];
  int           mismatches = 0;

  task automatic push_result(input event_kind_t kind, input logic [7:0] data,
                             input logic lst);
    result_t r;
    r.event_kind = kind;
    r.data_byte  = data;
    r.last       = lst;
    expected_q.push_back(r);
  endtask

  // Length is known: pong mask key or empty-text event, then pick next phase
  task automatic finish_header();
    if (rx_class == CL_PING) begin
      for (int k = 0; k < 4; k++)
        push_result(EV_PONG, 8'h00, (k == 3) && (rx_remaining == 0));
    end else if (rx_class == CL_TEXT && rx_remaining == 0) begin
      push_result(EV_EMPTY, 8'h00, 1'b0);
    end
    if (rx_remaining == 0) begin
      rx_phase = PH_HDR0;
    end else begin
      rx_phase = PH_PAYLOAD;
    end
  endtask

  // Expected results for one received byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [2:0] need;
    if (!rx_closed) begin
      case (rx_phase)
        PH_HDR0: begin
          rx_remaining = '0;
          len_index    = '0;
          if (b[3:0] == OP_CLOSE) begin
            rx_closed = 1'b1;
            push_result(EV_CLOSED, 8'h00, 1'b0);
          end else begin
            if (b[3:0] == OP_TEXT) begin
              rx_class = CL_TEXT;
            end else if (b[3:0] == OP_PING) begin
              rx_class = CL_PING;
              push_result(EV_PONG, (b & FLAGS_MASK) | OP_PONG, 1'b0);
            end else begin
              rx_class = CL_SKIP;
              push_result(EV_UNSUPP, 8'h00, 1'b0);
            end
            rx_phase = PH_HDR1;
          end
        end
        PH_HDR1: begin
          len_index    = '0;
          rx_remaining = '0;
          if (b[6:0] == LEN_EXT64) begin
            // 64-bit length: reported once, frame skipped
            if (rx_class != CL_SKIP) push_result(EV_LENERR, 8'h00, 1'b0);
            rx_class = CL_SKIP;
            rx_phase = PH_EXT64;
          end else begin
            if (rx_class == CL_PING) push_result(EV_PONG, b | MASK_BIT, 1'b0);
            if (b[6:0] == LEN_EXT16) begin
              rx_phase = PH_EXT16;
            end else begin
              rx_remaining = {25'd0, b[6:0]};
              finish_header();
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          need = (rx_phase == PH_EXT16) ? NEED_EXT16 : NEED_EXT64;
          if (rx_class == CL_PING) push_result(EV_PONG, b, 1'b0);
          // count saturates at 32 bits
          if (rx_remaining > 32'h00FF_FFFF) begin
            rx_remaining = '1;
          end else begin
            rx_remaining = {rx_remaining[23:0], b};
          end
          len_index = len_index + 3'd1;
          if (len_index == need) begin
            len_index = '0;
            finish_header();
          end
        end
        PH_PAYLOAD: begin
          if (rx_remaining != 0) rx_remaining = rx_remaining - 32'd1;
          if (rx_class == CL_TEXT) begin
            push_result(EV_TEXT, b, rx_remaining == 0);
          end else if (rx_class == CL_PING) begin
            push_result(EV_PONG, b, rx_remaining == 0);
          end
          if (rx_remaining == 0) rx_phase = PH_HDR0;
        end
        default: begin
          rx_phase = PH_HDR0;
        end
      endcase
    end
  endtask

  // Compare output transfers first, then predict from the input transfer
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rx_phase     = PH_HDR0;
      rx_class     = CL_TEXT;
      rx_remaining = '0;
      len_index    = '0;
      rx_closed    = 1'b0;
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d data %02h last %0d",
                     m_tuser, m_tdata, m_tlast);
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.event_kind || m_tdata !== want.data_byte ||
              m_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d data %02h last %0d,",
                       want.event_kind, want.data_byte, want.last,
                       " got kind %0d data %02h last %0d",
                       m_tuser, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
    end
    error_count   <= mismatches;
    pending_count <= expected_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import wsd_pkg::*;

  localparam int ITEM_TARGET  = 450;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {LF_SHORT, LF_EXT16, LF_EXT64} len_form_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  int error_count;
  int pending_count;
  int bytes_sent  = 0;
  int stall_cycles;
  bit idle_on     = 1'b1;

  websocket_frame_deframer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  deframer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    m_tready <= (idle_on && $urandom_range(99) < 36) ? 1'b0 : 1'b1;
  end

  // Watchdog: too long without any transfer
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // One received byte, with random gaps before it
  task automatic send_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Hold the input until every predicted result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin
    logic [7:0]  directed_bytes[$];
    logic [3:0]  opcode;
    logic [3:0]  flags;
    logic        mask_bit;
    logic [31:0] len;
    len_form_t   form;
    int          pick;

    directed_bytes = '{
      8'h81, 8'h00,                                   // empty text
      8'h81, 8'h81, 8'hFF,                            // one text byte, mask bit set
      8'h89, 8'h80,                                   // empty ping: five results at once
      8'h09, 8'h7E, 8'h00, 8'h02, 8'hFF, 8'h00,       // ping with 16-bit length
      8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,       // continuation, 64-bit length
      8'h00, 8'h00, 8'h00, 8'h01, 8'h5A,
      8'hF1, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,       // text with 64-bit length, empty
      8'h00, 8'h00, 8'h00, 8'h00
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain_results();

    // Random well-formed frames; unsupported opcodes act as noise
    while (bytes_sent < ITEM_TARGET) begin
      idle_on = !(bytes_sent >= 200 && bytes_sent < 300);
      pick = $urandom_range(99);
      if (pick < 40) begin
        opcode = OP_TEXT;
      end else if (pick < 70) begin
        opcode = OP_PING;
      end else begin
        opcode = 4'($urandom_range(15));
        while (opcode == OP_TEXT || opcode == OP_CLOSE || opcode == OP_PING)
          opcode = 4'($urandom_range(15));
      end
      flags    = 4'($urandom_range(15));
      mask_bit = 1'($urandom_range(1));
      pick     = $urandom_range(99);
      if (pick < 70) begin
        form = LF_SHORT;
        len  = ($urandom_range(9) == 0) ? $urandom_range(125) : $urandom_range(12);
      end else if (pick < 90) begin
        form = LF_EXT16;
        len  = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(20);
      end else begin
        form = LF_EXT64;
        len  = $urandom_range(8);
      end

      send_byte({flags, opcode});
      case (form)
        LF_SHORT: begin
          send_byte({mask_bit, len[6:0]});
        end
        LF_EXT16: begin
          send_byte({mask_bit, LEN_EXT16});
          send_byte(len[15:8]);
          send_byte(len[7:0]);
        end
        default: begin
          send_byte({mask_bit, LEN_EXT64});
          for (int i = 7; i >= 0; i--) send_byte((i < 4) ? len[8*i +: 8] : 8'h00);
        end
      endcase
      repeat (len) send_byte(8'($urandom_range(255)));

      if ($urandom_range(15) == 0) drain_results();
    end

    // Terminal frame: either a close, or a length error that saturates the count
    idle_on  = 1'b1;
    flags    = 4'($urandom_range(15));
    mask_bit = 1'($urandom_range(1));
    if ($urandom_range(1) == 1) begin
      send_byte({flags, OP_CLOSE});
    end else begin
      send_byte({flags, OP_TEXT});
      send_byte({mask_bit, LEN_EXT64});
      send_byte(8'($urandom_range(1, 255)));
      repeat (7) send_byte(8'($urandom_range(255)));
    end
    // everything after this is dropped silently
    repeat (12) send_byte(8'($urandom_range(255)));

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/wsd_pkg.sv
sv/wsd_decoder.sv
sv/wsd_result_fifo.sv
sv/websocket_frame_deframer.sv
test/deframer_checker.sv
test/tb_top.sv
